// ----- rtl/cbm_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cbm_pkg
// Decode codes, field widths and beat layouts for the cartridge bank mapper.
// ---------------------------------------------------------------------------
package cbm_pkg;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 104;

    localparam logic [15:0] ADDR_MASK     = 16'hF003;
    localparam logic [15:0] ADDR_SELECT   = 16'h8000;
    localparam logic [15:0] ADDR_DATA     = 16'h8001;
    localparam logic [15:0] ADDR_MIRROR   = 16'hA000;
    localparam logic [15:0] ADDR_LATCH    = 16'hC000;
    localparam logic [15:0] ADDR_RELOAD   = 16'hC001;
    localparam logic [15:0] ADDR_IRQ_OFF  = 16'hE000;
    localparam logic [15:0] ADDR_IRQ_ON   = 16'hE001;

    localparam logic       CMD_BUS_WRITE = 1'b0;
    localparam logic       CMD_TICK      = 1'b1;

    localparam logic [3:0] REG_PAT_PAIR0 = 4'h0;
    localparam logic [3:0] REG_PAT_PAIR1 = 4'h1;
    localparam logic [3:0] REG_PAT_2     = 4'h2;
    localparam logic [3:0] REG_PAT_3     = 4'h3;
    localparam logic [3:0] REG_PAT_4     = 4'h4;
    localparam logic [3:0] REG_PAT_5     = 4'h5;
    localparam logic [3:0] REG_PRG_6     = 4'h6;
    localparam logic [3:0] REG_PRG_7     = 4'h7;
    localparam logic [3:0] REG_PAT_8     = 4'h8;
    localparam logic [3:0] REG_PAT_9     = 4'h9;
    localparam logic [3:0] REG_PRG_F     = 4'hF;

    localparam logic [8:0] LAST_VISIBLE_LINE = 9'd239;
    localparam logic [7:0] LAST_BANK_RESET   = 8'hFF;

    typedef struct packed {
        logic              command;
        logic [15:0]       bus_address;
        logic [7:0]        bus_data;
        logic signed [9:0] scanline_number;
        logic              rendering_on;
    } in_item_t;

    typedef struct packed {
        logic [63:0] pattern_bank_map;
        logic [31:0] program_bank_map;
        logic        mirroring_horizontal;
        logic        irq_pulse;
    } out_item_t;

endpackage

// ----- rtl/cartridge_bank_mapper_with_scanline_irq.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cartridge_bank_mapper_with_scanline_irq
// Bank-switching mapper with a scanline interrupt counter.
// ---------------------------------------------------------------------------
// Input channel (s_axis): one beat is a CPU bus write (tuser = 0) or a
// scanline tick (tuser = 1). Output channel (m_axis): one beat per input
// beat, carrying the pattern and program bank maps, the mirroring bit and
// the interrupt pulse, all as they stand after that input beat.
// Configuration: cfg_wr_en / cfg_wr_data write the fixed bank number of the
// top program slot; write it only while no beat is in flight.
// Pipeline: an accepted input beat is held in the input register, then its
// result is registered in the result register. Throughput: one beat per
// cycle while m_axis_tready is high, set by the single pass of decode and
// update logic between the two registers.
// Reset: all slots return to their power-up banks, the IRQ is disarmed,
// the top program bank reads 255 and both channels are empty.
// Stall: while m_axis_tready is low the result is held; one more input
// beat is taken into the input register, then s_axis_tready drops.
// ---------------------------------------------------------------------------
module cartridge_bank_mapper_with_scanline_irq (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [7:0]                        cfg_wr_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [15:0] bus_address, [23:16] bus_data, [33:24] scanline_number,
    // [34] rendering_on, [39:35] zero
    input  logic [cbm_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // [0] command
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [63:0] pattern_bank_map, [95:64] program_bank_map,
    // [96] mirroring_horizontal, [97] irq_pulse, [103:98] zero
    output logic [cbm_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
    import cbm_pkg::*;

    logic        in_valid_reg;
    in_item_t    in_item_reg;
    logic        out_valid_reg;
    out_item_t   out_item_reg;
    out_item_t   out_item_next;
    logic        advance;

    logic [7:0]  last_bank_reg;
    logic [3:0]  reg_index_reg,  reg_index_next;
    logic        prg_mode_reg,   prg_mode_next;
    logic        pat_inv_reg,    pat_inv_next;
    logic [7:0]  pat_slot_reg  [8];
    logic [7:0]  pat_slot_next [8];
    logic [7:0]  prg_slot_reg  [3];
    logic [7:0]  prg_slot_next [3];
    logic        mirror_reg,     mirror_next;
    logic [7:0]  reload_reg,     reload_next;
    logic [7:0]  count_reg,      count_next;
    logic        armed_reg,      armed_next;
    logic        pulse_next;

    logic [15:0] addr_dec;
    logic [7:0]  wr_data;
    logic [7:0]  wr_data_inc;
    logic [7:0]  count_dec;
    logic        line_visible;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    assign addr_dec     = in_item_reg.bus_address & ADDR_MASK;
    assign wr_data      = in_item_reg.bus_data;
    assign wr_data_inc  = wr_data + 8'd1;
    assign count_dec    = count_reg - 8'd1;
    assign line_visible = !in_item_reg.scanline_number[9]
                          && (in_item_reg.scanline_number[8:0] <= LAST_VISIBLE_LINE);

    always_comb
    begin
        reg_index_next = reg_index_reg;
        prg_mode_next  = prg_mode_reg;
        pat_inv_next   = pat_inv_reg;
        pat_slot_next  = pat_slot_reg;
        prg_slot_next  = prg_slot_reg;
        mirror_next    = mirror_reg;
        reload_next    = reload_reg;
        count_next     = count_reg;
        armed_next     = armed_reg;
        pulse_next     = 1'b0;

        if (in_item_reg.command == CMD_BUS_WRITE)
        begin
            case (addr_dec)
                ADDR_SELECT:
                begin
                    reg_index_next = wr_data[3:0];
                    prg_mode_next  = wr_data[6];
                    pat_inv_next   = wr_data[7];
                end
                ADDR_DATA:
                begin
                    case (reg_index_reg)
                        REG_PAT_PAIR0:
                        begin
                            pat_slot_next[{pat_inv_reg, 2'd0}] = wr_data;
                            pat_slot_next[{pat_inv_reg, 2'd1}] = wr_data_inc;
                        end
                        REG_PAT_PAIR1:
                        begin
                            pat_slot_next[{pat_inv_reg, 2'd2}] = wr_data;
                            pat_slot_next[{pat_inv_reg, 2'd3}] = wr_data_inc;
                        end
                        REG_PAT_2, REG_PAT_3, REG_PAT_4, REG_PAT_5:
                        begin
                            pat_slot_next[{!pat_inv_reg, 2'(reg_index_reg - REG_PAT_2)}]
                                = wr_data;
                        end
                        REG_PRG_6: prg_slot_next[prg_mode_reg ? 2'd1 : 2'd0] = wr_data;
                        REG_PRG_7: prg_slot_next[prg_mode_reg ? 2'd2 : 2'd1] = wr_data;
                        REG_PAT_8: pat_slot_next[{pat_inv_reg, 2'd1}] = wr_data;
                        REG_PAT_9: pat_slot_next[{pat_inv_reg, 2'd3}] = wr_data;
                        REG_PRG_F: prg_slot_next[prg_mode_reg ? 2'd0 : 2'd2] = wr_data;
                        default:   ;
                    endcase
                end
                ADDR_MIRROR:  mirror_next = wr_data[0];
                ADDR_LATCH:
                begin
                    reload_next = wr_data;
                    count_next  = wr_data;
                end
                ADDR_RELOAD:  count_next = reload_reg;
                ADDR_IRQ_OFF:
                begin
                    armed_next = 1'b0;
                    count_next = reload_reg;
                end
                ADDR_IRQ_ON:
                begin
                    armed_next = 1'b1;
                    count_next = reload_reg;
                end
                default: ;
            endcase
        end
        else if (armed_reg && line_visible && in_item_reg.rendering_on)
        begin
            if (count_dec == 8'd0)
            begin
                count_next = reload_reg;
                pulse_next = 1'b1;
            end
            else
            begin
                count_next = count_dec;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            out_item_next.pattern_bank_map[i*8 +: 8] = pat_slot_next[i];
        end
        out_item_next.program_bank_map     = {last_bank_reg, prg_slot_next[2],
                                              prg_slot_next[1], prg_slot_next[0]};
        out_item_next.mirroring_horizontal = mirror_next;
        out_item_next.irq_pulse            = pulse_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_bank_reg <= LAST_BANK_RESET;
            reg_index_reg <= 4'd0;
            prg_mode_reg  <= 1'b0;
            pat_inv_reg   <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                pat_slot_reg[i] <= 8'(i);
            end
            for (int i = 0; i < 3; i++)
            begin
                prg_slot_reg[i] <= 8'd0;
            end
            mirror_reg    <= 1'b0;
            reload_reg    <= 8'd0;
            count_reg     <= 8'd0;
            armed_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                last_bank_reg <= cfg_wr_data;
            end
            if (advance)
            begin
                reg_index_reg <= reg_index_next;
                prg_mode_reg  <= prg_mode_next;
                pat_inv_reg   <= pat_inv_next;
                pat_slot_reg  <= pat_slot_next;
                prg_slot_reg  <= prg_slot_next;
                mirror_reg    <= mirror_next;
                reload_reg    <= reload_next;
                count_reg     <= count_next;
                armed_reg     <= armed_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_item_reg.command         <= s_axis_tuser;
            in_item_reg.bus_address     <= s_axis_tdata[15:0];
            in_item_reg.bus_data        <= s_axis_tdata[23:16];
            in_item_reg.scanline_number <= s_axis_tdata[33:24];
            in_item_reg.rendering_on    <= s_axis_tdata[34];
        end
        if (advance)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_item_reg.irq_pulse, out_item_reg.mirroring_horizontal,
                            out_item_reg.program_bank_map, out_item_reg.pattern_bank_map};

    a_bus_write_no_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (in_item_reg.command == CMD_BUS_WRITE) |=> !out_item_reg.irq_pulse)
        else $error("irq pulse on a bus write");

    a_pulse_reloads: assert property (@(posedge clk) disable iff (!rst_n)
        advance && pulse_next |=> (count_reg == reload_reg))
        else $error("counter not reloaded after pulse");

    a_pulse_needs_arm: assert property (@(posedge clk) disable iff (!rst_n)
        pulse_next |-> armed_reg && in_item_reg.rendering_on && line_visible)
        else $error("pulse without counting tick");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_axis_tready)
        else $error("input stalled while input register empty");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_axis_tready |=> out_valid_reg && $stable(m_axis_tdata))
        else $error("result lost during stall");

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Checks the cartridge bank mapper against an in-bench model of its bank
// slots, mirroring bit and scanline IRQ counter. Every accepted input beat
// updates the model and queues the expected result beat; a monitor compares
// each result beat field by field. Directed corner cases come first, then
// randomized select/data sequences, IRQ bursts and bus noise under several
// sender idle and receiver stall mixes, with the top program bank rewritten
// between phases.
// ---------------------------------------------------------------------------
module testbench;

    import cbm_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [7:0]            cfg_wr_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // [15:0] bus_address, [23:16] bus_data, [33:24] scanline_number,
    // [34] rendering_on, [39:35] zero
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    // [0] command
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // [63:0] pattern_bank_map, [95:64] program_bank_map,
    // [96] mirroring_horizontal, [97] irq_pulse, [103:98] zero
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    // mapper model state
    logic [7:0] pat_slot [8];
    logic [7:0] prg_slot [3];
    logic [7:0] last_bank;
    logic [3:0] sel_index;
    logic       prg_mode;
    logic       pat_invert;
    logic       mirror_h;
    logic [7:0] mdl_reload;
    logic [7:0] mdl_count;
    logic       mdl_armed;

    out_item_t  expected_maps [$];
    int         mismatch_count;
    int         cycle_count;
    int         sender_idle_pct;
    int         recv_stall_pct;

    cartridge_bank_mapper_with_scanline_irq dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("cartridge_bank_mapper_with_scanline_irq test failed");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin : check_results
        out_item_t got;
        out_item_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.pattern_bank_map     = m_axis_tdata[63:0];
            got.program_bank_map     = m_axis_tdata[95:64];
            got.mirroring_horizontal = m_axis_tdata[96];
            got.irq_pulse            = m_axis_tdata[97];
            if (expected_maps.size() == 0)
            begin
                $display("%0t: unexpected result beat %h", $time, m_axis_tdata);
                mismatch_count++;
            end
            else
            begin
                want = expected_maps.pop_front();
                if (got.pattern_bank_map !== want.pattern_bank_map)
                begin
                    $display("%0t: pattern_bank_map expected %h actual %h",
                             $time, want.pattern_bank_map, got.pattern_bank_map);
                    mismatch_count++;
                end
                if (got.program_bank_map !== want.program_bank_map)
                begin
                    $display("%0t: program_bank_map expected %h actual %h",
                             $time, want.program_bank_map, got.program_bank_map);
                    mismatch_count++;
                end
                if (got.mirroring_horizontal !== want.mirroring_horizontal)
                begin
                    $display("%0t: mirroring_horizontal expected %b actual %b",
                             $time, want.mirroring_horizontal, got.mirroring_horizontal);
                    mismatch_count++;
                end
                if (got.irq_pulse !== want.irq_pulse)
                begin
                    $display("%0t: irq_pulse expected %b actual %b",
                             $time, want.irq_pulse, got.irq_pulse);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic reset_mapper_model();
        for (int i = 0; i < 8; i++)
            pat_slot[i] = 8'(i);
        for (int i = 0; i < 3; i++)
            prg_slot[i] = 8'd0;
        last_bank   = LAST_BANK_RESET;
        sel_index   = 4'd0;
        prg_mode    = 1'b0;
        pat_invert  = 1'b0;
        mirror_h    = 1'b0;
        mdl_reload  = 8'd0;
        mdl_count   = 8'd0;
        mdl_armed   = 1'b0;
    endtask

    task automatic predict_mapper_beat(input in_item_t beat);
        out_item_t         res;
        logic [7:0]        d;
        logic [7:0]        d_next;
        logic signed [9:0] scan;
        int                line;
        res    = '0;
        d      = beat.bus_data;
        d_next = d + 8'd1;
        scan   = beat.scanline_number;
        line   = scan;
        if (beat.command == CMD_BUS_WRITE)
        begin
            case (beat.bus_address & ADDR_MASK)
                ADDR_SELECT:
                begin
                    sel_index  = d[3:0];
                    prg_mode   = d[6];
                    pat_invert = d[7];
                end
                ADDR_DATA:
                begin
                    case (sel_index)
                        REG_PAT_PAIR0:
                        begin
                            pat_slot[pat_invert ? 4 : 0] = d;
                            pat_slot[pat_invert ? 5 : 1] = d_next;
                        end
                        REG_PAT_PAIR1:
                        begin
                            pat_slot[pat_invert ? 6 : 2] = d;
                            pat_slot[pat_invert ? 7 : 3] = d_next;
                        end
                        REG_PAT_2, REG_PAT_3, REG_PAT_4, REG_PAT_5:
                            pat_slot[int'(sel_index) - 2 + (pat_invert ? 0 : 4)] = d;
                        REG_PRG_6: prg_slot[prg_mode ? 1 : 0] = d;
                        REG_PRG_7: prg_slot[prg_mode ? 2 : 1] = d;
                        REG_PAT_8: pat_slot[pat_invert ? 5 : 1] = d;
                        REG_PAT_9: pat_slot[pat_invert ? 7 : 3] = d;
                        REG_PRG_F: prg_slot[prg_mode ? 0 : 2] = d;
                        default: ;
                    endcase
                end
                ADDR_MIRROR: mirror_h = d[0];
                ADDR_LATCH:
                begin
                    mdl_reload = d;
                    mdl_count  = d;
                end
                ADDR_RELOAD: mdl_count = mdl_reload;
                ADDR_IRQ_OFF:
                begin
                    mdl_armed = 1'b0;
                    mdl_count = mdl_reload;
                end
                ADDR_IRQ_ON:
                begin
                    mdl_armed = 1'b1;
                    mdl_count = mdl_reload;
                end
                default: ;
            endcase
        end
        else if (mdl_armed && line >= 0 && line <= int'(LAST_VISIBLE_LINE)
                 && beat.rendering_on)
        begin
            mdl_count = mdl_count - 8'd1;
            if (mdl_count == 8'd0)
            begin
                mdl_count     = mdl_reload;
                res.irq_pulse = 1'b1;
            end
        end
        for (int i = 0; i < 8; i++)
            res.pattern_bank_map[8*i +: 8] = pat_slot[i];
        res.program_bank_map     = {last_bank, prg_slot[2], prg_slot[1], prg_slot[0]};
        res.mirroring_horizontal = mirror_h;
        expected_maps.push_back(res);
    endtask

    function automatic logic [15:0] decoded_addr(input logic [15:0] code);
        return code | (16'($urandom) & ~ADDR_MASK);
    endfunction

    function automatic in_item_t bus_beat(input logic [15:0] addr, input logic [7:0] data);
        in_item_t beat;
        beat.command         = CMD_BUS_WRITE;
        beat.bus_address     = addr;
        beat.bus_data        = data;
        beat.scanline_number = 10'(int'($urandom_range(262)) - 1);
        beat.rendering_on    = 1'($urandom);
        return beat;
    endfunction

    function automatic in_item_t tick_beat(input int line, input logic render);
        in_item_t beat;
        beat.command         = CMD_TICK;
        beat.bus_address     = 16'($urandom);
        beat.bus_data        = 8'($urandom);
        beat.scanline_number = 10'(line);
        beat.rendering_on    = render;
        return beat;
    endfunction

    task automatic send_beat(input in_item_t beat);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, beat.rendering_on, beat.scanline_number,
                          beat.bus_data, beat.bus_address};
        s_axis_tuser  <= beat.command;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_mapper_beat(beat);
        @(negedge clk);
    endtask

    task automatic wait_for_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_maps.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_last_bank(input logic [7:0] value);
        wait_for_idle();
        cfg_wr_data <= value;
        cfg_wr_en   <= 1'b1;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        last_bank = value;
    endtask

    task automatic test_special_cases();
        send_beat(tick_beat(0, 1'b1));
        send_beat(bus_beat(ADDR_SELECT, {4'h0, REG_PAT_PAIR0}));
        send_beat(bus_beat(ADDR_DATA, 8'hFF));
        send_beat(bus_beat(ADDR_SELECT, {4'h4, REG_PRG_6}));
        send_beat(bus_beat(ADDR_DATA, 8'h12));
        send_beat(bus_beat(ADDR_SELECT, 8'h0C));
        send_beat(bus_beat(ADDR_DATA, 8'h55));
        send_beat(bus_beat(ADDR_SELECT, {4'h8, REG_PRG_F}));
        send_beat(bus_beat(ADDR_DATA, 8'hAB));
        send_beat(bus_beat(ADDR_MIRROR, 8'h01));
        send_beat(bus_beat(16'h9000, 8'hFF));
        send_beat(bus_beat(ADDR_LATCH, 8'h02));
        send_beat(bus_beat(ADDR_IRQ_ON, 8'h00));
        send_beat(tick_beat(-1, 1'b1));
        send_beat(tick_beat(240, 1'b1));
        send_beat(tick_beat(0, 1'b0));
        send_beat(tick_beat(0, 1'b1));
        send_beat(tick_beat(239, 1'b1));
        send_beat(bus_beat(ADDR_LATCH, 8'h00));
        send_beat(tick_beat(100, 1'b1));
        send_beat(bus_beat(ADDR_RELOAD, 8'h00));
        send_beat(bus_beat(ADDR_IRQ_OFF, 8'h00));
        send_beat(tick_beat(261, 1'b1));
        send_beat(bus_beat(ADDR_MIRROR, 8'hFE));
        send_beat(bus_beat(16'hFFFF, 8'hFF));
    endtask

    task automatic test_bank_switching(input int count);
        int sent;
        int writes;
        sent = 0;
        while (sent < count)
        begin
            send_beat(bus_beat(decoded_addr(ADDR_SELECT), 8'($urandom)));
            writes = $urandom_range(1, 3);
            repeat (writes)
            begin
                if ($urandom_range(7) == 0)
                    send_beat(bus_beat(decoded_addr(ADDR_MIRROR), 8'($urandom)));
                else
                    send_beat(bus_beat(decoded_addr(ADDR_DATA), 8'($urandom)));
            end
            sent += writes + 1;
        end
    endtask

    task automatic test_scanline_irq(input int count);
        int  sent;
        int  burst;
        int  line;
        bit  paused;
        sent   = 0;
        paused = 1'b0;
        while (sent < count)
        begin
            if ($urandom_range(3) == 0)
                send_beat(bus_beat(decoded_addr(ADDR_LATCH), 8'($urandom)));
            else
                send_beat(bus_beat(decoded_addr(ADDR_LATCH), 8'($urandom_range(6))));
            if ($urandom_range(2) == 0)
            begin
                send_beat(bus_beat(decoded_addr(ADDR_RELOAD), 8'($urandom)));
                sent++;
            end
            if ($urandom_range(4) == 0)
                send_beat(bus_beat(decoded_addr(ADDR_IRQ_OFF), 8'($urandom)));
            else
                send_beat(bus_beat(decoded_addr(ADDR_IRQ_ON), 8'($urandom)));
            burst = $urandom_range(4, 20);
            repeat (burst)
            begin
                if ($urandom_range(9) == 0)
                    line = int'($urandom_range(262)) - 1;
                else
                    line = $urandom_range(239);
                send_beat(tick_beat(line, 1'($urandom_range(7) != 0)));
            end
            sent += burst + 2;
            // hold off until the pipeline has fully drained
            if (!paused && sent >= count / 2)
            begin
                wait_for_idle();
                paused = 1'b1;
            end
        end
    endtask

    task automatic test_bus_noise(input int count);
        in_item_t beat;
        repeat (count)
        begin
            if ($urandom_range(1) == 0)
                beat = tick_beat(int'($urandom_range(262)) - 1, 1'($urandom));
            else if ($urandom_range(1) == 0)
                beat = bus_beat(16'($urandom), 8'($urandom));
            else
                beat = bus_beat(decoded_addr(ADDR_DATA), 8'($urandom));
            send_beat(beat);
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_wr_data     = 8'd0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        s_axis_tuser    = CMD_BUS_WRITE;
        m_axis_tready   = 1'b0;
        mismatch_count  = 0;
        cycle_count     = 0;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        reset_mapper_model();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_special_cases();
        write_last_bank(8'h00);
        test_special_cases();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 47; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 47; end
                default: begin sender_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            case (phase)
                0: write_last_bank(8'hFF);
                2: write_last_bank(8'h80);
                default: write_last_bank(8'($urandom));
            endcase
            test_bank_switching(90);
            test_scanline_irq(90);
            test_bus_noise(20);
        end

        wait_for_idle();
        if (mismatch_count == 0)
            $display("cartridge_bank_mapper_with_scanline_irq test passed");
        else
            $display("cartridge_bank_mapper_with_scanline_irq test failed");
        $finish;
    end

endmodule
